// ----- hw/rtl/stpd_pkg.sv -----
// shared types and constants of the smoothing threshold peak detector
package stpd_pkg;

   localparam int SampleWidth = 16;
   localparam int IndexWidth  = 16;
   localparam int SumWidth    = SampleWidth + 2;
   localparam int QueueDepth  = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);

   localparam logic [IndexWidth-1:0] INDEX_LIMIT = {IndexWidth{1'b1}};

   localparam logic CSR_HIGH_THRESHOLD = 1'b0;
   localparam logic CSR_LOW_THRESHOLD  = 1'b1;

   // smoothed values that one input item gives
   typedef struct packed {
      logic                          has_first;
      logic signed [SampleWidth-1:0] first_value;
      logic                          has_last;
      logic signed [SampleWidth-1:0] last_value;
   } entry_type;

   typedef struct packed {
      logic signed [SampleWidth-1:0] smoothed;
      logic [IndexWidth-1:0]         index;
      logic                          alarm;
      logic                          end_of_record;
      logic signed [SampleWidth-1:0] peak_value;
      logic [IndexWidth-1:0]         peak_index;
   } result_type;

endpackage

// ----- hw/rtl/stpd_front.sv -----
// front part: sample window and 1:2:1 smoothing with edge weights
module stpd_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   accept,
   input  logic signed [stpd_pkg::SampleWidth-1:0] sample,
   input  logic                                   last,
   output logic                                   push,
   output stpd_pkg::entry_type                    entry
);

   logic signed [stpd_pkg::SampleWidth-1:0] older_ff, older_in;
   logic signed [stpd_pkg::SampleWidth-1:0] newer_ff, newer_in;
   logic held_ff, held_in;
   logic have_older_ff, have_older_in;

   logic signed [stpd_pkg::SumWidth-1:0] x_ext, newer_ext, older_ext;
   logic signed [stpd_pkg::SumWidth-1:0] first_sum, last_sum;

   always_comb begin
      x_ext     = stpd_pkg::SumWidth'(sample);
      newer_ext = stpd_pkg::SumWidth'(newer_ff);
      older_ext = stpd_pkg::SumWidth'(older_ff);
      if (have_older_ff) begin
         first_sum = older_ext + (newer_ext <<< 1) + x_ext;
      end else begin
         first_sum = newer_ext + (newer_ext <<< 1) + x_ext;
      end
      if (held_ff) begin
         last_sum = newer_ext + x_ext + (x_ext <<< 1);
      end else begin
         last_sum = x_ext + (x_ext <<< 1);
      end
      // floor of sum / 4
      entry.has_first   = held_ff;
      entry.first_value = first_sum[stpd_pkg::SumWidth-1:2];
      entry.has_last    = last;
      entry.last_value  = last_sum[stpd_pkg::SumWidth-1:2];
      push = accept && (held_ff || last);
   end

   always_comb begin
      older_in      = older_ff;
      newer_in      = newer_ff;
      held_in       = held_ff;
      have_older_in = have_older_ff;
      if (accept) begin
         if (last) begin
            held_in       = 1'b0;
            have_older_in = 1'b0;
         end else begin
            older_in      = newer_ff;
            newer_in      = sample;
            have_older_in = held_ff;
            held_in       = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      older_ff <= older_in;
      newer_ff <= newer_in;
      if (reset) begin
         held_ff       <= 1'b0;
         have_older_ff <= 1'b0;
      end else begin
         held_ff       <= held_in;
         have_older_ff <= have_older_in;
      end
   end

endmodule

// ----- hw/rtl/stpd_queue.sv -----
// short queue of smoothed entries between front and back
module stpd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  stpd_pkg::entry_type push_entry,
   input  logic                pop,
   output logic                full,
   output logic                not_empty,
   output stpd_pkg::entry_type head
);

   stpd_pkg::entry_type slots [stpd_pkg::QueueDepth];

   logic [stpd_pkg::QueuePtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [stpd_pkg::QueuePtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [stpd_pkg::QueuePtrWidth:0]   count_ff, count_in;
   logic do_push, do_pop;

   always_comb begin
      full      = (count_ff == (stpd_pkg::QueuePtrWidth+1)'(stpd_pkg::QueueDepth));
      not_empty = (count_ff != '0);
      head      = slots[rd_ptr_ff];
      do_push   = push && !full;
      do_pop    = pop && not_empty;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hw/rtl/stpd_back.sv -----
// back part: hysteresis alarm, running peak, index and result register
module stpd_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   entry_valid,
   input  stpd_pkg::entry_type                    entry,
   output logic                                   entry_pop,
   input  logic signed [stpd_pkg::SampleWidth-1:0] high_threshold,
   input  logic signed [stpd_pkg::SampleWidth-1:0] low_threshold,
   input  logic                                   result_pop,
   output logic                                   result_valid,
   output stpd_pkg::result_type                   result
);

   logic phase_ff, phase_in;
   logic disarmed_ff, disarmed_in;
   logic signed [stpd_pkg::SampleWidth-1:0] best_value_ff, best_value_in;
   logic [stpd_pkg::IndexWidth-1:0] best_index_ff, best_index_in;
   logic [stpd_pkg::IndexWidth-1:0] count_ff, count_in;
   logic out_valid_ff, out_valid_in;
   stpd_pkg::result_type out_ff, out_in;

   logic step, take_first, is_end, alarm, new_best;
   logic signed [stpd_pkg::SampleWidth-1:0] value, peak_value;
   logic [stpd_pkg::IndexWidth-1:0] peak_index;

   always_comb begin
      step       = entry_valid && (!out_valid_ff || result_pop);
      take_first = entry.has_first && !phase_ff;
      value      = take_first ? entry.first_value : entry.last_value;
      is_end     = !take_first;
      alarm      = (value > high_threshold) && !disarmed_ff;
      new_best   = (count_ff == '0) || (value > best_value_ff);
      peak_value = new_best ? value : best_value_ff;
      peak_index = new_best ? count_ff : best_index_ff;
      entry_pop  = step && !(take_first && entry.has_last);

      phase_in      = phase_ff;
      disarmed_in   = disarmed_ff;
      best_value_in = best_value_ff;
      best_index_in = best_index_ff;
      count_in      = count_ff;
      out_valid_in  = out_valid_ff && !result_pop;
      out_in        = out_ff;

      if (step) begin
         out_valid_in          = 1'b1;
         out_in.smoothed       = value;
         out_in.index          = count_ff;
         out_in.alarm          = alarm;
         out_in.end_of_record  = is_end;
         out_in.peak_value     = is_end ? peak_value : '0;
         out_in.peak_index     = is_end ? peak_index : '0;
         if (is_end) begin
            phase_in      = 1'b0;
            disarmed_in   = 1'b0;
            best_value_in = '0;
            best_index_in = '0;
            count_in      = '0;
         end else begin
            phase_in      = entry.has_last;
            best_value_in = peak_value;
            best_index_in = peak_index;
            if (alarm) begin
               disarmed_in = 1'b1;
            end else if ((value < low_threshold) && disarmed_ff) begin
               disarmed_in = 1'b0;
            end
            if (count_ff < stpd_pkg::INDEX_LIMIT) begin
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   assign result_valid = out_valid_ff;
   assign result       = out_ff;

   always_ff @(posedge clock) begin
      out_ff        <= out_in;
      best_value_ff <= best_value_in;
      best_index_ff <= best_index_in;
      if (reset) begin
         phase_ff     <= 1'b0;
         disarmed_ff  <= 1'b0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         disarmed_ff  <= disarmed_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ----- hw/rtl/smooth_threshold_peak_detector.sv -----
// top level: threshold registers, front part, entry queue and back part
// a smoothed result is computed when the sample to its right is transferred, then passes through
// the entry queue and the result register, and waits while an earlier result is not popped
// one sample per cycle sustained while results are popped; a record's final sample can yield two
// results from one entry, emitted in turn by the back part, and the four-entry queue absorbs that
// reset clears the record counters and flags and loads the thresholds with 2511 and 1280
module smooth_threshold_peak_detector (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_push,
   output logic                                    req_full,
   input  logic signed [stpd_pkg::SampleWidth-1:0] req_sample,
   input  logic                                    req_last,
   output logic                                    rsp_empty,
   input  logic                                    rsp_pop,
   output logic signed [stpd_pkg::SampleWidth-1:0] rsp_smoothed,
   output logic [stpd_pkg::IndexWidth-1:0]         rsp_index,
   output logic                                    rsp_alarm,
   output logic                                    rsp_end_of_record,
   output logic signed [stpd_pkg::SampleWidth-1:0] rsp_peak_value,
   output logic [stpd_pkg::IndexWidth-1:0]         rsp_peak_index,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic                                    csr_index,
   input  logic [stpd_pkg::SampleWidth-1:0]        csr_data
);

   logic signed [stpd_pkg::SampleWidth-1:0] high_threshold_ff, low_threshold_ff;
   logic accept, push, queue_full, queue_valid, queue_pop, result_valid;
   stpd_pkg::entry_type push_entry, head;
   stpd_pkg::result_type result;

   assign csr_ready = 1'b1;
   assign req_full  = queue_full;
   assign accept    = req_push && !queue_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         high_threshold_ff <= 16'sd2511;
         low_threshold_ff  <= 16'sd1280;
      end else if (csr_valid) begin
         case (csr_index)
            stpd_pkg::CSR_HIGH_THRESHOLD: high_threshold_ff <= csr_data;
            stpd_pkg::CSR_LOW_THRESHOLD:  low_threshold_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   stpd_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .sample (req_sample),
      .last   (req_last),
      .push   (push),
      .entry  (push_entry)
   );

   stpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (queue_pop),
      .full       (queue_full),
      .not_empty  (queue_valid),
      .head       (head)
   );

   stpd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .entry_valid    (queue_valid),
      .entry          (head),
      .entry_pop      (queue_pop),
      .high_threshold (high_threshold_ff),
      .low_threshold  (low_threshold_ff),
      .result_pop     (rsp_pop),
      .result_valid   (result_valid),
      .result         (result)
   );

   assign rsp_empty         = !result_valid;
   assign rsp_smoothed      = result.smoothed;
   assign rsp_index         = result.index;
   assign rsp_alarm         = result.alarm;
   assign rsp_end_of_record = result.end_of_record;
   assign rsp_peak_value    = result.peak_value;
   assign rsp_peak_index    = result.peak_index;

endmodule

// ----- tb/tb_smooth_threshold_peak_detector.sv -----
// self-checking testbench for the smoothing threshold peak detector with a record-level predictor
module tb_smooth_threshold_peak_detector;

   logic                          clock;
   logic                          reset;
   logic                          req_push;
   logic                          req_full;
   logic signed [15:0]            req_sample;
   logic                          req_last;
   logic                          rsp_empty;
   logic                          rsp_pop;
   logic signed [15:0]            rsp_smoothed;
   logic [15:0]                   rsp_index;
   logic                          rsp_alarm;
   logic                          rsp_end_of_record;
   logic signed [15:0]            rsp_peak_value;
   logic [15:0]                   rsp_peak_index;
   logic                          csr_valid;
   logic                          csr_ready;
   logic                          csr_index;
   logic [15:0]                   csr_data;

   smooth_threshold_peak_detector u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_sample        (req_sample),
      .req_last          (req_last),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_smoothed      (rsp_smoothed),
      .rsp_index         (rsp_index),
      .rsp_alarm         (rsp_alarm),
      .rsp_end_of_record (rsp_end_of_record),
      .rsp_peak_value    (rsp_peak_value),
      .rsp_peak_index    (rsp_peak_index),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // predictor state
   logic signed [15:0] high_thr = 16'sd2511;
   logic signed [15:0] low_thr  = 16'sd1280;
   logic signed [15:0] older_raw;
   logic signed [15:0] newer_raw;
   logic               raw_held;
   logic [15:0]        result_count;
   logic               disarmed;
   logic signed [15:0] best_value;
   logic [15:0]        best_index;

   stpd_pkg::result_type expected_results[$];

   int error_count   = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles   = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic void clear_record();
      older_raw    = '0;
      newer_raw    = '0;
      raw_held     = 1'b0;
      result_count = '0;
      disarmed     = 1'b0;
      best_value   = '0;
      best_index   = '0;
   endfunction

   function automatic logic signed [15:0] quarter_floor(input int weighted_sum);
      int q;
      q = weighted_sum >>> 2;
      return q[15:0];
   endfunction

   function automatic void emit_smoothed(input logic signed [15:0] value, input logic is_end);
      stpd_pkg::result_type r;
      r.smoothed = value;
      r.index    = result_count;
      r.alarm    = 1'b0;
      if (value > high_thr && !disarmed) begin
         r.alarm  = 1'b1;
         disarmed = 1'b1;
      end else if (value < low_thr && disarmed) begin
         disarmed = 1'b0;
      end
      if (result_count == 16'd0 || value > best_value) begin
         best_value = value;
         best_index = result_count;
      end
      if (result_count != stpd_pkg::INDEX_LIMIT)
         result_count = result_count + 16'd1;
      r.end_of_record = is_end;
      r.peak_value    = is_end ? best_value : 16'sd0;
      r.peak_index    = is_end ? best_index : 16'd0;
      expected_results.push_back(r);
   endfunction

   function automatic void predict_smoothing(input logic signed [15:0] sample,
                                             input logic is_last);
      int xs;
      int xn;
      int xo;
      xs = sample;
      xn = newer_raw;
      xo = older_raw;
      if (raw_held) begin
         if (result_count == 16'd0)
            emit_smoothed(quarter_floor(3 * xn + xs), 1'b0);
         else
            emit_smoothed(quarter_floor(xo + 2 * xn + xs), 1'b0);
      end
      if (is_last) begin
         emit_smoothed(raw_held ? quarter_floor(xn + 3 * xs) : quarter_floor(3 * xs), 1'b1);
         clear_record();
      end else begin
         older_raw = newer_raw;
         newer_raw = sample;
         raw_held  = 1'b1;
      end
   endfunction

   function automatic void report_failure(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      error_count++;
   endfunction

   function automatic void compare_field(input string name, input logic [15:0] got,
                                         input logic [15:0] want);
      if (got !== want)
         report_failure($sformatf("%s got %h expected %h", name, got, want));
   endfunction

   function automatic void check_result();
      stpd_pkg::result_type want;
      if (expected_results.size() == 0) begin
         report_failure($sformatf("result %h index %0d with nothing expected",
                                  rsp_smoothed, rsp_index));
         return;
      end
      want = expected_results.pop_front();
      compare_field("smoothed", rsp_smoothed, want.smoothed);
      compare_field("index", rsp_index, want.index);
      compare_field("alarm", 16'(rsp_alarm), 16'(want.alarm));
      compare_field("end_of_record", 16'(rsp_end_of_record), 16'(want.end_of_record));
      compare_field("peak_value", rsp_peak_value, want.peak_value);
      compare_field("peak_index", rsp_peak_index, want.peak_index);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         check_result();
   end

   // result side: random idling, or a long hold-off when asked
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_sample(input logic signed [15:0] sample, input logic is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_push <= 1'b0;
      end
      @(negedge clock);
      req_push   <= 1'b1;
      req_sample <= sample;
      req_last   <= is_last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_smoothing(sample, is_last);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_push <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_threshold(input logic which, input logic signed [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (which == stpd_pkg::CSR_HIGH_THRESHOLD)
         high_thr = value;
      else
         low_thr = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_thresholds(input logic signed [15:0] high, input logic signed [15:0] low);
      drain_results();
      write_threshold(stpd_pkg::CSR_HIGH_THRESHOLD, high);
      write_threshold(stpd_pkg::CSR_LOW_THRESHOLD, low);
   endtask

   function automatic logic signed [15:0] random_sample();
      int v;
      case ($urandom_range(3))
         0: v = $urandom_range(65535) - 32768;
         1: v = int'(high_thr) + $urandom_range(2000) - 1000;
         2: v = int'(low_thr) + $urandom_range(2000) - 1000;
         default: v = $urandom_range(1) ? 32767 : -32768;
      endcase
      if (v > 32767)
         v = 32767;
      if (v < -32768)
         v = -32768;
      return 16'(v);
   endfunction

   task automatic send_random_record(input int len);
      for (int i = 0; i < len; i++)
         send_sample(random_sample(), i == len - 1);
   endtask

   task automatic send_random_records(input int item_goal);
      int sent;
      int pick;
      int len;
      sent = 0;
      while (sent < item_goal) begin
         pick = $urandom_range(99);
         if (pick < 5)
            len = $urandom_range(1, 2);
         else if (pick < 75)
            len = $urandom_range(3, 12);
         else
            len = $urandom_range(13, 60);
         send_random_record(len);
         sent += len;
      end
   endtask

   task automatic test_edge_weights();
      send_sample(16'sd32767, 1'b1);
      send_sample(-16'sd32768, 1'b1);
      send_sample(-16'sd1, 1'b1);
      send_sample(16'sd32767, 1'b0);
      send_sample(-16'sd32768, 1'b1);
      send_sample(-16'sd32768, 1'b0);
      send_sample(16'sd32767, 1'b0);
      send_sample(-16'sd3, 1'b1);
      drain_results();
   endtask

   task automatic test_hysteresis();
      int levels [0:10] = '{0, 4000, 4000, 2000, 2000, 4000, 4000, 0, 0, 4000, 4000};
      for (int i = 0; i <= 10; i++)
         send_sample(16'(levels[i]), i == 10);
      drain_results();
   endtask

   task automatic test_peak_ties();
      int levels [0:4] = '{100, 500, 100, 500, 100};
      for (int i = 0; i <= 4; i++)
         send_sample(16'(levels[i]), i == 4);
      drain_results();
   endtask

   task automatic test_random_records();
      logic signed [15:0] lo;
      send_idle_pct = 30;
      recv_idle_pct = 46;
      send_random_records(80);
      set_thresholds(16'($urandom_range(65535)), 16'($urandom_range(65535)));
      send_random_records(80);

      set_thresholds(16'sd32767, -16'sd32768);
      send_idle_pct = 46;
      recv_idle_pct = 30;
      send_random_records(80);
      set_thresholds(-16'sd32768, 16'sd32767);
      send_random_records(80);

      lo = 16'($urandom_range(3000));
      set_thresholds(lo + 16'($urandom_range(3000)), lo);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random_records(80);
      set_thresholds(16'sd2511, 16'sd1280);
      send_random_records(80);
      drain_results();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      hold_cycles   = 150;
      send_random_records(40);
      // sender stops and waits until every expected result has been checked
      drain_results();
   endtask

   initial begin
      reset      = 1'b1;
      req_push   = 1'b0;
      req_sample = '0;
      req_last   = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = stpd_pkg::CSR_HIGH_THRESHOLD;
      csr_data   = '0;
      clear_record();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 30;
      recv_idle_pct = 46;
      test_edge_weights();
      test_hysteresis();
      test_peak_ties();
      test_random_records();
      test_backpressure();

      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/stpd_pkg.sv
hw/rtl/stpd_front.sv
hw/rtl/stpd_queue.sv
hw/rtl/stpd_back.sv
hw/rtl/smooth_threshold_peak_detector.sv
tb/tb_smooth_threshold_peak_detector.sv
